// File: hw/rtl/multi_pin_switch_debouncer_assert.svh
// Assertion macros shared by the debouncer RTL.
// The checking forms are left out when SYNTH is defined.
`ifndef MULTI_PIN_SWITCH_DEBOUNCER_ASSERT_SVH
`define MULTI_PIN_SWITCH_DEBOUNCER_ASSERT_SVH
`ifndef SYNTH
`define MPSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MPSD_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define MPSD_ASSERT(lbl, prop, msg)
`define MPSD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: hw/rtl/mpsd_pkg.sv
package mpsd_pkg;

  localparam int LevelW     = 29;
  localparam int TimeW      = 32;
  localparam int WinW       = 20;
  localparam int IdxW       = 5;
  localparam int MaxPins    = 48;
  localparam int MaxResults = 29;
  localparam int EmitCntW   = 5;
  localparam int CfgIdxW    = 8;
  localparam int CfgDataW   = 32;
  localparam int InDataW    = 64;
  localparam int OutDataW   = 8;

  localparam logic [WinW-1:0] WindowReset    = 20'd10000;
  localparam logic            ActiveLowReset = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    RegWindow    = 8'd0,
    RegActiveLow = 8'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    IdleSt,
    ScanSt,
    FlushSt
  } state_e;

  // Request from the sequencer to the event stage.
  typedef struct packed {
    logic            push;
    logic            flush;
    logic [IdxW-1:0] pin;
    logic            level;
    logic            active;
  } ev_op_t;

  // Status returned by the event stage.
  typedef struct packed {
    logic ready;
    logic hold_vld;
  } ev_stat_t;

endpackage

// File: hw/rtl/multi_pin_switch_debouncer.sv
// Sweep: accept in idle, then one pin per cycle through the shared elapsed-time comparator
// unless an event finds the hold slot blocked, then the flush state; a new sweep is taken only
// back in idle. The first sweep after reset only loads levels and the block is ready again on
// the next cycle. Output: an event leaves the hold slot when the next event is found or at the
// flush, so the final event of a sweep reaches the output register at the flush.
// Reset (rst_ni, asynchronous, active low) clears pending flags, stable levels and the loaded
// flag, sets the window to 10000 us and the polarity to active low.
`include "multi_pin_switch_debouncer_assert.svh"

module multi_pin_switch_debouncer #(
  parameter int NUM_PINS = 29
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mpsd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [mpsd_pkg::CfgDataW-1:0] cfg_data_i,
  // Sweep input.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata, lowest bit up: pin_levels[28:0], now_us[60:29], zero pad[63:61].
  input  logic [mpsd_pkg::InDataW-1:0]  s_axis_tdata,
  // Change events.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata, lowest bit up: pin_index[4:0], new_level[5], is_active[6], zero pad[7].
  output logic [mpsd_pkg::OutDataW-1:0] m_axis_tdata,
  // tlast carries last_event.
  output logic                          m_axis_tlast
);

  localparam int PinW     = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
  localparam int LevelW   = mpsd_pkg::LevelW;
  localparam int TimeW    = mpsd_pkg::TimeW;
  localparam int MaxPins  = mpsd_pkg::MaxPins;
  localparam int EmitCntW = mpsd_pkg::EmitCntW;
  localparam int MaxIdxW  = $clog2(MaxPins);

  // Configuration registers. The user must write them only while the block is idle; the block does not enforce it.
  logic [mpsd_pkg::WinW-1:0] win_q;
  logic                      act_low_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= mpsd_pkg::WindowReset;
      act_low_q <= mpsd_pkg::ActiveLowReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mpsd_pkg::RegWindow:    win_q     <= cfg_data_i[mpsd_pkg::WinW-1:0];
        mpsd_pkg::RegActiveLow: act_low_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer and per-pin state.
  mpsd_pkg::state_e          state_q, state_d;
  logic [PinW-1:0]           cnt_q, cnt_d;
  logic [EmitCntW-1:0]       emit_cnt_q, emit_cnt_d;
  logic                      loaded_q, loaded_d;
  logic [NUM_PINS-1:0]       stable_q, stable_d;
  logic [NUM_PINS-1:0]       pend_q, pend_d;
  logic [TimeW-1:0]          start_q [NUM_PINS];
  logic [LevelW-1:0]         lv_q;
  logic [TimeW-1:0]          now_q;

  logic                      s_accept;
  logic [MaxPins-1:0]        in_ext;
  logic [MaxPins-1:0]        lv_ext;
  logic [MaxIdxW-1:0]        pin_wide;
  logic                      lvl;
  logic                      differs;
  logic                      pend_cur;
  logic                      reached;
  logic                      accept_ev;
  logic                      emit;
  logic                      stall;
  logic                      start_we;
  mpsd_pkg::ev_op_t          op;
  mpsd_pkg::ev_stat_t        stat;

  assign s_axis_tready = (state_q == mpsd_pkg::IdleSt);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Pins beyond the sampled field read as low.
  assign in_ext   = {{(MaxPins - LevelW){1'b0}}, s_axis_tdata[LevelW-1:0]};
  assign lv_ext   = {{(MaxPins - LevelW){1'b0}}, lv_q};
  assign pin_wide = MaxIdxW'(cnt_q);
  assign lvl      = lv_ext[pin_wide];
  assign differs  = lvl != stable_q[cnt_q];
  assign pend_cur = pend_q[cnt_q];

  // The one comparator serves every pin in turn.
  mpsd_elapsed_cmp u_cmp (
    .now_i     (now_q),
    .start_i   (start_q[cnt_q]),
    .window_i  (win_q),
    .reached_o (reached)
  );

  assign accept_ev = differs && pend_cur && reached;
  // Past the result limit the pin still settles, but no event goes out.
  assign emit      = accept_ev && (emit_cnt_q < EmitCntW'(mpsd_pkg::MaxResults));
  // An event that finds the hold slot blocked freezes the scan on this pin.
  assign stall     = emit && !stat.ready;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    emit_cnt_d = emit_cnt_q;
    loaded_d   = loaded_q;
    stable_d   = stable_q;
    pend_d     = pend_q;
    start_we   = 1'b0;
    op.push    = 1'b0;
    op.flush   = 1'b0;
    op.pin     = pin_wide[mpsd_pkg::IdxW-1:0];
    op.level   = lvl;
    op.active  = act_low_q ? !lvl : lvl;
    unique case (state_q)
      mpsd_pkg::IdleSt: begin
        if (s_accept) begin
          if (!loaded_q) begin
            // The first sweep only sets the stable levels.
            stable_d = in_ext[NUM_PINS-1:0];
            pend_d   = '0;
            loaded_d = 1'b1;
          end else begin
            state_d    = mpsd_pkg::ScanSt;
            cnt_d      = '0;
            emit_cnt_d = '0;
          end
        end
      end
      mpsd_pkg::ScanSt: begin
        if (!stall) begin
          if (differs && !pend_cur) begin
            pend_d[cnt_q] = 1'b1;
            start_we      = 1'b1;
          end else if (accept_ev) begin
            stable_d[cnt_q] = lvl;
            pend_d[cnt_q]   = 1'b0;
            if (emit) begin
              op.push    = 1'b1;
              emit_cnt_d = emit_cnt_q + EmitCntW'(1);
            end
          end else if (!differs) begin
            pend_d[cnt_q] = 1'b0;
          end
          if (cnt_q == PinW'(NUM_PINS - 1)) begin
            state_d = mpsd_pkg::FlushSt;
          end else begin
            cnt_d = cnt_q + PinW'(1);
          end
        end
      end
      mpsd_pkg::FlushSt: begin
        // The held event, if any, is the final one of this sweep.
        if (stat.ready) begin
          op.flush = 1'b1;
          state_d  = mpsd_pkg::IdleSt;
        end
      end
      default: state_d = mpsd_pkg::IdleSt;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= mpsd_pkg::IdleSt;
      cnt_q      <= '0;
      emit_cnt_q <= '0;
      loaded_q   <= 1'b0;
      stable_q   <= '0;
      pend_q     <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      emit_cnt_q <= emit_cnt_d;
      loaded_q   <= loaded_d;
      stable_q   <= stable_d;
      pend_q     <= pend_d;
    end
  end

  // Sweep payload and window start times; a start time is read only while
  // its pending flag is set, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      lv_q  <= s_axis_tdata[LevelW-1:0];
      now_q <= s_axis_tdata[LevelW+TimeW-1:LevelW];
    end
    if (start_we) begin
      start_q[cnt_q] <= now_q;
    end
  end

  mpsd_event_out u_evt (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .stat_o        (stat),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  `MPSD_ASSERT(a_cnt_range, (state_q == mpsd_pkg::ScanSt) |-> (cnt_q <= PinW'(NUM_PINS - 1)), "pin counter out of range")
  `MPSD_ASSERT(a_emit_max, emit_cnt_q <= EmitCntW'(mpsd_pkg::MaxResults), "too many events in one sweep")
  `MPSD_ASSERT(a_idle_empty, (state_q == mpsd_pkg::IdleSt) |-> !stat.hold_vld, "event held while idle")
  `MPSD_ASSERT_NEXT(a_loaded, s_accept, loaded_q, "sweep taken without loading levels")
  `MPSD_ASSERT_NEXT(a_stall_hold, (state_q == mpsd_pkg::ScanSt) && stall, $stable(cnt_q), "scan advanced while stalled")

endmodule

// File: hw/rtl/mpsd_elapsed_cmp.sv
// Wrapping elapsed time against the debounce window.
module mpsd_elapsed_cmp (
  input  logic [mpsd_pkg::TimeW-1:0] now_i,
  input  logic [mpsd_pkg::TimeW-1:0] start_i,
  input  logic [mpsd_pkg::WinW-1:0]  window_i,
  output logic                       reached_o
);

  logic [mpsd_pkg::TimeW-1:0] elapsed;

  assign elapsed   = now_i - start_i;
  assign reached_o = elapsed >= {{(mpsd_pkg::TimeW - mpsd_pkg::WinW){1'b0}}, window_i};

endmodule

// File: hw/rtl/mpsd_event_out.sv
// One-event hold slot in front of the output register. An event waits in
// the slot until the next one shows up or the sweep ends, which tells
// whether it is the final event of its sweep.
module mpsd_event_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mpsd_pkg::ev_op_t              op_i,
  output mpsd_pkg::ev_stat_t            stat_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mpsd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast
);

  logic                          hold_vld_q, hold_vld_d;
  logic [mpsd_pkg::IdxW-1:0]     hold_pin_q, hold_pin_d;
  logic                          hold_lvl_q, hold_lvl_d;
  logic                          hold_act_q, hold_act_d;
  logic                          out_vld_q, out_vld_d;
  logic [mpsd_pkg::OutDataW-1:0] out_data_q, out_data_d;
  logic                          out_last_q, out_last_d;
  logic                          out_free;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign stat_o.ready    = !hold_vld_q || out_free;
  assign stat_o.hold_vld = hold_vld_q;

  always_comb begin
    hold_vld_d = hold_vld_q;
    hold_pin_d = hold_pin_q;
    hold_lvl_d = hold_lvl_q;
    hold_act_d = hold_act_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    out_last_d = out_last_q;
    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (op_i.push) begin
      if (hold_vld_q) begin
        out_vld_d  = 1'b1;
        out_data_d = {1'b0, hold_act_q, hold_lvl_q, hold_pin_q};
        out_last_d = 1'b0;
      end
      hold_vld_d = 1'b1;
      hold_pin_d = op_i.pin;
      hold_lvl_d = op_i.level;
      hold_act_d = op_i.active;
    end else if (op_i.flush && hold_vld_q) begin
      out_vld_d  = 1'b1;
      out_data_d = {1'b0, hold_act_q, hold_lvl_q, hold_pin_q};
      out_last_d = 1'b1;
      hold_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_pin_q <= hold_pin_d;
    hold_lvl_q <= hold_lvl_d;
    hold_act_q <= hold_act_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
